// ----- src/sfc_pkg.sv -----
// Shared types and constants for the stuffed frame checker.
`default_nettype none
package sfc_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'hFF;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [2:0] MIN_POS   = 3'd3;
  localparam logic [2:0] SAT_POS   = 3'd4;
  localparam int unsigned TYPE_BITS = 64;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_TOO_SHORT = 3'd2,
    ST_BAD_SUM   = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload;
    status_t    status;
    logic [7:0] ftype;
  } result_t;

endpackage
`default_nettype wire

// ----- src/sfc_in_stage.sv -----
// Input request register of the stuffed frame checker.
`default_nettype none
module sfc_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte_in,
  input  wire logic       in_end_of_frame,
  input  wire logic       advance,
  output logic            s1_valid,
  output logic [7:0]      s1_byte,
  output logic            s1_eof
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       eof_r;
  logic       take;

  assign in_ready  = !valid_r || advance;
  assign take      = in_valid && in_ready;
  assign valid_nxt = take ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (take) begin
      byte_r <= in_byte_in;
      eof_r  <= in_end_of_frame;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;
  assign s1_eof   = eof_r;

endmodule
`default_nettype wire

// ----- src/sfc_core.sv -----
// Frame state, destuffing, checksum and status decision.
`default_nettype none
module sfc_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [63:0]       cfg_wr_data,
  input  wire logic              advance,
  input  wire logic              s1_valid,
  input  wire logic [7:0]        s1_byte,
  input  wire logic              s1_eof,
  output logic                   has_result,
  output sfc_pkg::result_t       result
);
  import sfc_pkg::*;

  logic [63:0] types_r;
  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic        prev_ff_r, prev_ff_nxt;
  logic        start_r, start_nxt;
  logic [7:0]  type_r, type_nxt;
  logic        start_ok;
  logic        is_ff;
  logic        type_known;
  status_t     status;

  assign is_ff    = (s1_byte == FLAG_BYTE);
  assign start_ok = start_r
                    && !((pos_r == 3'd0) && !is_ff)
                    && !((pos_r == 3'd1) && (s1_byte != ZERO_BYTE));
  assign type_known = (type_r < 8'(TYPE_BITS)) && types_r[type_r[5:0]];

  always_comb begin
    if (!start_ok) begin
      status = ST_BAD_START;
    end else if (pos_r < MIN_POS) begin
      status = ST_TOO_SHORT;
    end else if (s1_byte != xor_r) begin
      status = ST_BAD_SUM;
    end else if (!type_known) begin
      status = ST_UNKNOWN;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    xor_nxt     = xor_r;
    prev_ff_nxt = prev_ff_r;
    start_nxt   = start_r;
    type_nxt    = type_r;
    has_result  = 1'b0;
    result      = '{kind: KIND_PAYLOAD, payload: 8'd0, status: ST_OK, ftype: 8'd0};
    if (s1_eof) begin
      has_result  = 1'b1;
      result      = '{kind: KIND_STATUS, payload: 8'd0, status: status, ftype: type_r};
      pos_nxt     = 3'd0;
      xor_nxt     = 8'd0;
      prev_ff_nxt = 1'b0;
      start_nxt   = 1'b1;
      type_nxt    = 8'd0;
    end else begin
      start_nxt = start_ok;
      xor_nxt   = xor_r ^ s1_byte;
      if (pos_r == 3'd2) begin
        type_nxt = s1_byte;
      end
      if (pos_r >= MIN_POS) begin
        if (pos_r < SAT_POS) begin
          pos_nxt = pos_r + 3'd1;
        end
        if (start_ok) begin
          if (prev_ff_r && is_ff) begin
            prev_ff_nxt = 1'b0;
          end else begin
            prev_ff_nxt = is_ff;
            has_result  = 1'b1;
            result      = '{kind: KIND_PAYLOAD, payload: s1_byte, status: ST_OK,
                            ftype: 8'd0};
          end
        end
      end else begin
        pos_nxt = pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      types_r   <= 64'hFF;
      pos_r     <= 3'd0;
      xor_r     <= 8'd0;
      prev_ff_r <= 1'b0;
      start_r   <= 1'b1;
      type_r    <= 8'd0;
    end else begin
      if (cfg_wr_en) begin
        types_r <= cfg_wr_data;
      end
      if (advance && s1_valid) begin
        pos_r     <= pos_nxt;
        xor_r     <= xor_nxt;
        prev_ff_r <= prev_ff_nxt;
        start_r   <= start_nxt;
        type_r    <= type_nxt;
      end
    end
  end

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= SAT_POS) else $error("byte position beyond saturation");

  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_valid && s1_eof) |=> (pos_r == 3'd0 && xor_r == 8'd0 && start_r))
    else $error("frame state not cleared after last byte");

  a_no_payload_bad_start: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !s1_eof && !start_ok) |-> !has_result)
    else $error("payload emitted for frame with bad start");

  a_payload_after_header: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !s1_eof && has_result) |-> (pos_r >= MIN_POS))
    else $error("payload emitted inside header");

endmodule
`default_nettype wire

// ----- src/sfc_out_stage.sv -----
// Result register of the stuffed frame checker.
`default_nettype none
module sfc_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              s1_valid,
  input  wire logic              has_result,
  input  wire sfc_pkg::result_t  result,
  output logic                   advance,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_kind,
  output logic [7:0]             out_payload_byte,
  output logic [2:0]             out_frame_status,
  output logic [7:0]             out_frame_type
);
  import sfc_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;
  logic    can_load;
  logic    load;

  assign can_load  = !valid_r || out_ready;
  assign advance   = s1_valid && can_load;
  assign load      = advance && has_result;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      res_r <= result;
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = res_r.kind;
  assign out_payload_byte = res_r.payload;
  assign out_frame_status = res_r.status;
  assign out_frame_type   = res_r.ftype;

endmodule
`default_nettype wire

// ----- src/stuffed_frame_checker.sv -----
// Top level of the stuffed frame checker: destuffs payload and reports frame status.
// A byte moves from the input register through the combinational core into the result register.
// Throughput: one byte per cycle while the result register is empty or being read out.
// A result waiting in the result register stalls the core; the input register holds one byte.
// Reset (rst_n low, synchronous): pipeline empty, frame state cleared, type mask 0xFF.
`default_nettype none
module stuffed_frame_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_in,
  input  wire logic        in_end_of_frame,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [7:0]       out_payload_byte,
  output logic [2:0]       out_frame_status,
  output logic [7:0]       out_frame_type,
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data
);
  import sfc_pkg::*;

  logic       advance;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eof;
  logic       has_result;
  result_t    result;

  sfc_in_stage u_in (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte_in      (in_byte_in),
    .in_end_of_frame (in_end_of_frame),
    .advance         (advance),
    .s1_valid        (s1_valid),
    .s1_byte         (s1_byte),
    .s1_eof          (s1_eof)
  );

  sfc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .s1_valid    (s1_valid),
    .s1_byte     (s1_byte),
    .s1_eof      (s1_eof),
    .has_result  (has_result),
    .result      (result)
  );

  sfc_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .s1_valid         (s1_valid),
    .has_result       (has_result),
    .result           (result),
    .advance          (advance),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_status (out_frame_status),
    .out_frame_type   (out_frame_type)
  );

endmodule
`default_nettype wire

// ----- tb/sv/tb_stuffed_frame_checker.sv -----
// Self-checking testbench for the stuffed frame checker: directed table, random frames, type masks.
module tb_stuffed_frame_checker;
  timeunit 1ns;
  timeprecision 1ps;

  import sfc_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int SETTLE_CYCLES = 4;
  localparam int SQUEEZE_CYCLES = 80;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_MASKS = 5;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       eof;
    logic       typed;
    status_t    status;
    logic [7:0] ftype;
  } stim_row_t;

  localparam int NUM_ROWS = 23;
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{8'hFF, 1'b0, 1'b0, ST_OK, 8'h00},
    '{8'h00, 1'b0, 1'b0, ST_OK, 8'h00},
    '{8'h03, 1'b0, 1'b0, ST_OK, 8'h00},
    '{8'hFF, 1'b0, 1'b0, ST_OK, 8'h00},
    '{8'hFF, 1'b0, 1'b0, ST_OK, 8'h00},
    '{8'hFF, 1'b0, 1'b0, ST_OK, 8'h00},
    '{8'h03, 1'b1, 1'b1, ST_OK, 8'h03},
    '{8'hFF, 1'b1, 1'b1, ST_TOO_SHORT, 8'h00},
    '{8'h00, 1'b1, 1'b1, ST_BAD_START, 8'h00},
    '{8'hFF, 1'b0, 1'b0, ST_OK, 8'h00},
    '{8'h00, 1'b1, 1'b1, ST_TOO_SHORT, 8'h00},
    '{8'hFF, 1'b0, 1'b0, ST_OK, 8'h00},
    '{8'h00, 1'b0, 1'b0, ST_OK, 8'h00},
    '{8'h07, 1'b0, 1'b0, ST_OK, 8'h00},
    '{8'h12, 1'b1, 1'b1, ST_BAD_SUM, 8'h07},
    '{8'hFF, 1'b0, 1'b0, ST_OK, 8'h00},
    '{8'h00, 1'b0, 1'b0, ST_OK, 8'h00},
    '{8'hFF, 1'b0, 1'b0, ST_OK, 8'h00},
    '{8'h00, 1'b1, 1'b1, ST_UNKNOWN, 8'hFF},
    '{8'hFF, 1'b0, 1'b0, ST_OK, 8'h00},
    '{8'h01, 1'b0, 1'b0, ST_OK, 8'h00},
    '{8'h05, 1'b0, 1'b0, ST_OK, 8'h00},
    '{8'h00, 1'b1, 1'b1, ST_BAD_START, 8'h05}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_in = 8'h00;
  logic        in_end_of_frame = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [7:0]  out_payload_byte;
  logic [2:0]  out_frame_status;
  logic [7:0]  out_frame_type;
  logic        cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = 64'h0;

  stuffed_frame_checker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_in       (in_byte_in),
    .in_end_of_frame  (in_end_of_frame),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_status (out_frame_status),
    .out_frame_type   (out_frame_type),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // frame tracking state
  logic [63:0] type_mask = 64'hFF;
  logic [2:0]  frame_pos = 3'd0;
  logic [7:0]  running_xor = 8'h00;
  logic        last_kept_ff = 1'b0;
  logic        start_good = 1'b1;
  logic [7:0]  frame_type_seen = 8'h00;

  result_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int requests_in = 0;
  int payload_out = 0;
  int status_tally [5] = '{0, 0, 0, 0, 0};
  int gap_pct = 0;
  bit calm = 1'b0;
  bit squeeze_req = 1'b0;
  bit squeeze_done = 1'b0;
  int hold_left = 0;

  task automatic clear_frame();
    frame_pos = 3'd0;
    running_xor = 8'h00;
    last_kept_ff = 1'b0;
    start_good = 1'b1;
    frame_type_seen = 8'h00;
  endtask

  task automatic track_frame_byte(input logic [7:0] b, input logic eof);
    logic    ok;
    result_t r;
    ok = start_good;
    if (frame_pos == 3'd0 && b != FLAG_BYTE) ok = 1'b0;
    if (frame_pos == 3'd1 && b != ZERO_BYTE) ok = 1'b0;
    if (eof) begin
      r.kind = KIND_STATUS;
      r.payload = 8'h00;
      r.ftype = frame_type_seen;
      if (!ok) r.status = ST_BAD_START;
      else if (frame_pos < MIN_POS) r.status = ST_TOO_SHORT;
      else if (b != running_xor) r.status = ST_BAD_SUM;
      else if (frame_type_seen >= TYPE_BITS || !type_mask[frame_type_seen[5:0]])
        r.status = ST_UNKNOWN;
      else r.status = ST_OK;
      expected_results.push_back(r);
      clear_frame();
    end else begin
      start_good = ok;
      running_xor = running_xor ^ b;
      if (frame_pos == 3'd2) frame_type_seen = b;
      if (frame_pos >= MIN_POS) begin
        if (frame_pos < SAT_POS) frame_pos = frame_pos + 3'd1;
        if (start_good) begin
          if (last_kept_ff && b == FLAG_BYTE) begin
            last_kept_ff = 1'b0;
          end else begin
            last_kept_ff = (b == FLAG_BYTE);
            r.kind = KIND_PAYLOAD;
            r.payload = b;
            r.status = ST_OK;
            r.ftype = 8'h00;
            expected_results.push_back(r);
          end
        end
      end else begin
        frame_pos = frame_pos + 3'd1;
      end
    end
  endtask

  // called on a falling edge; returns on the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic eof);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte_in <= b;
    in_end_of_frame <= eof;
    do @(posedge clk); while (!in_ready);
    track_frame_byte(b, eof);
    requests_in++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mask(input logic [63:0] m);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    type_mask = m;
  endtask

  task automatic send_frame();
    logic [7:0] raw[$];
    logic       eofs[$];
    logic [7:0] sum;
    int n, pick;
    gap_pct = calm ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30));
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      raw.push_back(FLAG_BYTE);
      raw.push_back(ZERO_BYTE);
      if ($urandom_range(0, 9) == 0) raw.push_back(8'($urandom_range(64, 255)));
      else raw.push_back(8'($urandom_range(0, 63)));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      repeat (n) begin
        if ($urandom_range(0, 2) == 0) begin
          raw.push_back(FLAG_BYTE);
          if ($urandom_range(0, 4) != 0) raw.push_back(FLAG_BYTE);
        end else begin
          raw.push_back(8'($urandom));
        end
      end
      sum = 8'h00;
      foreach (raw[i]) sum = sum ^ raw[i];
      if ($urandom_range(0, 6) == 0) sum = sum ^ 8'($urandom_range(1, 255));
      raw.push_back(sum);
    end else if (pick < 90) begin
      raw.push_back($urandom_range(0, 1) ? FLAG_BYTE : 8'($urandom));
      raw.push_back($urandom_range(0, 1) ? ZERO_BYTE : 8'($urandom));
      repeat (4) raw.push_back(8'($urandom));
      n = $urandom_range(1, 6);
      while (raw.size() > n) void'(raw.pop_back());
      if (n > 1 && $urandom_range(0, 1) == 1) begin
        sum = 8'h00;
        for (int i = 0; i < n - 1; i++) sum = sum ^ raw[i];
        raw[n - 1] = sum;
      end
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) raw.push_back(8'($urandom));
    end
    foreach (raw[i]) begin
      if (i == raw.size() - 1) eofs.push_back(1'b1);
      else if (pick >= 90) eofs.push_back($urandom_range(0, 4) == 0);
      else eofs.push_back(1'b0);
    end
    foreach (raw[i]) send_byte(raw[i], eofs[i]);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("tb_stuffed_frame_checker: done, errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (squeeze_req && !squeeze_done) begin
      squeeze_done = 1'b1;
      hold_left = SQUEEZE_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      hold_left = $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_field(input string name, input int want, input int got);
    errors++;
    if (errors <= 40)
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (out_kind == KIND_STATUS && out_frame_status < 3'd5)
        status_tally[out_frame_status]++;
      else if (out_kind == KIND_PAYLOAD)
        payload_out++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected result: expected none, ", $time,
                   "actual kind %0d byte %02h status %0d type %02h",
                   out_kind, out_payload_byte, out_frame_status, out_frame_type);
      end else begin
        want = expected_results.pop_front();
        if (out_kind !== want.kind) report_field("kind", want.kind, out_kind);
        if (out_payload_byte !== want.payload)
          report_field("payload_byte", want.payload, out_payload_byte);
        if (out_frame_status !== want.status)
          report_field("frame_status", want.status, out_frame_status);
        if (out_frame_type !== want.ftype)
          report_field("frame_type", want.ftype, out_frame_type);
      end
    end
  end

  initial begin
    logic [63:0] masks [NUM_MASKS];
    int target;
    masks[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    masks[1] = 64'h0;
    masks[2] = 64'h8000_0000_0000_0001;
    masks[3] = {$urandom, $urandom};
    masks[4] = 64'hFF;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    gap_pct = 20;
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].byte_val, directed_rows[i].eof);
      if (directed_rows[i].typed)
        expected_results[expected_results.size() - 1] =
          '{KIND_STATUS, 8'h00, directed_rows[i].status, directed_rows[i].ftype};
    end
    drain();

    for (int p = 0; p < NUM_MASKS; p++) begin
      write_mask(masks[p]);
      calm = (p == NUM_MASKS - 1);
      target = requests_in + ITEMS_PER_PHASE;
      while (requests_in < target) begin
        if (p == 1 && requests_in > target - ITEMS_PER_PHASE / 2) squeeze_req = 1'b1;
        send_frame();
      end
      drain();
    end

    $display("covered %0d requests in, %0d payload bytes out, %0d type masks",
             requests_in, payload_out, NUM_MASKS + 1);
    $display("statuses: ok %0d, bad start %0d, too short %0d, bad sum %0d, unknown type %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (errors == 0) begin
      $display("tb_stuffed_frame_checker: done, clean");
    end else begin
      $display("tb_stuffed_frame_checker: done, errors");
    end
    $finish;
  end

endmodule
